[src/bgsa_pkg.sv]
// Shared package for the banded global sequence aligner.
// Holds sizes, codes, the controller command and status structs; no dependencies.
package bgsa_pkg;

    localparam int MAX_LEN    = 256;
    localparam int BAND       = 3;
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int DIR_WIDTH  = 2 * BAND + 1;
    localparam int DIR_DEPTH  = (MAX_LEN + 1) * DIR_WIDTH;
    localparam int DIR_AW     = $clog2(DIR_DEPTH);
    localparam int PATH_DEPTH = 2 * MAX_LEN;
    localparam int PATH_AW    = $clog2(PATH_DEPTH);
    localparam int CNT_W      = PATH_AW + 1;
    localparam int ROW_W      = 2 * BAND + 2;
    localparam int STEP_W     = $clog2(ROW_W + 1);
    localparam int POS_W      = LEN_W + 2;
    localparam int SCORE_W    = 16;

    localparam logic [7:0] GAP_SYM  = 8'd45;
    localparam logic [7:0] WILD_SYM = 8'd78;

    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    localparam logic [3:0] MATCH_RESET    = 4'd1;
    localparam logic [3:0] MISMATCH_RESET = 4'd1;
    localparam logic [5:0] GAP_RESET      = 6'd20;

    typedef logic signed [SCORE_W-1:0] score_t;

    typedef enum logic [1:0] {
        DIR_DIAG = 2'd0,
        DIR_LEFT = 2'd1,
        DIR_UP   = 2'd2,
        DIR_NONE = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_ALIGN       = 2'd2,
        OP_READ        = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_ALIGNED   = 2'd0,
        ST_IDENTICAL = 2'd1,
        ST_REJECTED  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        logic    load_first;
        logic    load_second;
        logic    cmp_start;
        logic    cmp_rd;
        logic    cmp_chk;
        logic    set_kind;
        status_t kind;
        logic    fill_init;
        logic    row_rd;
        logic    cell_rd;
        logic    cell_calc;
        logic    row_end;
        logic    tb_init;
        logic    tb_rd;
        logic    tb_step;
        logic    align_done;
        logic    rd_issue;
        logic    rd_out;
    } cmd_t;

    typedef struct packed {
        logic same_len;
        logic len_zero;
        logic reject;
        logic cmp_equal;
        logic cmp_last;
        logic row_cell_last;
        logic row_last;
        logic tb_end;
        logic rd_avail;
    } sts_t;

endpackage

[src/bgsa_ctrl.sv]
// Controller state machine of the banded aligner.
// Depends on bgsa_pkg; drives the datapath through cmd_t and reads sts_t.
module bgsa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       opcode,
    input  bgsa_pkg::sts_t   sts,
    output bgsa_pkg::cmd_t   cmd,
    output logic             busy,
    output logic             done
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_CMP_RD    = 11'b000_0000_0010,
        S_CMP_CHK   = 11'b000_0000_0100,
        S_ROW_RD    = 11'b000_0000_1000,
        S_CELL_RD   = 11'b000_0001_0000,
        S_CELL_CALC = 11'b000_0010_0000,
        S_ROW_END   = 11'b000_0100_0000,
        S_TB_RD     = 11'b000_1000_0000,
        S_TB_STEP   = 11'b001_0000_0000,
        S_DONE      = 11'b010_0000_0000,
        S_RD_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    bgsa_pkg::opcode_t op;

    assign op = bgsa_pkg::opcode_t'(opcode);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        bgsa_pkg::OP_LOAD_FIRST:  cmd.load_first  = 1'b1;
                        bgsa_pkg::OP_LOAD_SECOND: cmd.load_second = 1'b1;
                        bgsa_pkg::OP_ALIGN:
                        begin
                            if (sts.same_len && sts.len_zero)
                            begin
                                cmd.set_kind = 1'b1;
                                cmd.kind     = bgsa_pkg::ST_IDENTICAL;
                                state_next   = S_DONE;
                            end
                            else if (sts.same_len)
                            begin
                                cmd.cmp_start = 1'b1;
                                state_next    = S_CMP_RD;
                            end
                            else if (sts.reject)
                            begin
                                cmd.set_kind = 1'b1;
                                cmd.kind     = bgsa_pkg::ST_REJECTED;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                cmd.fill_init = 1'b1;
                                state_next    = S_ROW_RD;
                            end
                        end
                        default:
                        begin
                            if (sts.rd_avail)
                            begin
                                cmd.rd_issue = 1'b1;
                                state_next   = S_RD_OUT;
                            end
                        end
                    endcase
                end
            end
            S_CMP_RD:
            begin
                cmd.cmp_rd = 1'b1;
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                cmd.cmp_chk = 1'b1;
                if (!sts.cmp_equal)
                begin
                    if (sts.reject)
                    begin
                        cmd.set_kind = 1'b1;
                        cmd.kind     = bgsa_pkg::ST_REJECTED;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.fill_init = 1'b1;
                        state_next    = S_ROW_RD;
                    end
                end
                else if (sts.cmp_last)
                begin
                    cmd.set_kind = 1'b1;
                    cmd.kind     = bgsa_pkg::ST_IDENTICAL;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_CMP_RD;
                end
            end
            S_ROW_RD:
            begin
                cmd.row_rd = 1'b1;
                state_next = S_CELL_RD;
            end
            S_CELL_RD:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = S_CELL_CALC;
            end
            S_CELL_CALC:
            begin
                cmd.cell_calc = 1'b1;
                state_next    = sts.row_cell_last ? S_ROW_END : S_CELL_RD;
            end
            S_ROW_END:
            begin
                cmd.row_end = 1'b1;
                if (sts.row_last)
                begin
                    cmd.tb_init  = 1'b1;
                    cmd.set_kind = 1'b1;
                    cmd.kind     = bgsa_pkg::ST_ALIGNED;
                    state_next   = S_TB_RD;
                end
                else
                begin
                    state_next = S_ROW_RD;
                end
            end
            S_TB_RD:
            begin
                if (sts.tb_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.tb_rd  = 1'b1;
                    state_next = S_TB_STEP;
                end
            end
            S_TB_STEP:
            begin
                cmd.tb_step = 1'b1;
                state_next  = S_TB_RD;
            end
            S_DONE:
            begin
                cmd.align_done = 1'b1;
                state_next     = S_IDLE;
            end
            S_RD_OUT:
            begin
                cmd.rd_out = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE) || (state_reg == S_RD_OUT);

endmodule

[src/bgsa_dp.sv]
// Datapath of the banded aligner: sequence stores, band score rows, direction
// and path memories, configuration registers and result formatting. Uses bgsa_pkg.
module bgsa_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bgsa_pkg::cmd_t                  cmd,
    output bgsa_pkg::sts_t                  sts,
    input  logic [7:0]                      symbol,
    input  logic                            cfg_valid,
    input  logic [1:0]                      cfg_index,
    input  logic [5:0]                      cfg_data,
    output logic [1:0]                      status,
    output logic signed [bgsa_pkg::SCORE_W-1:0] score,
    output logic [bgsa_pkg::CNT_W-1:0]      column_count,
    output logic [7:0]                      first_column_symbol,
    output logic [7:0]                      second_column_symbol,
    output logic                            last_column
);

    localparam int ADDR_W  = bgsa_pkg::ADDR_W;
    localparam int LEN_W   = bgsa_pkg::LEN_W;
    localparam int POS_W   = bgsa_pkg::POS_W;
    localparam int STEP_W  = bgsa_pkg::STEP_W;
    localparam int ROW_W   = bgsa_pkg::ROW_W;
    localparam int SCORE_W = bgsa_pkg::SCORE_W;
    localparam int DIR_AW  = bgsa_pkg::DIR_AW;
    localparam int PATH_AW = bgsa_pkg::PATH_AW;
    localparam int CNT_W   = bgsa_pkg::CNT_W;

    logic [7:0] seq1_mem [bgsa_pkg::MAX_LEN];
    logic [7:0] seq2_mem [bgsa_pkg::MAX_LEN];
    logic [1:0] dir_mem  [bgsa_pkg::DIR_DEPTH];
    logic [1:0] path_mem [bgsa_pkg::PATH_DEPTH];

    logic [3:0]           match_reg, mismatch_reg;
    logic [5:0]           gap_reg;
    logic [LEN_W-1:0]     len1_reg, len2_reg;
    logic                 ovf_reg;
    logic [CNT_W-1:0]     path_len_reg, ptr_reg;
    logic [LEN_W-1:0]     rd_i_reg, rd_j_reg;
    bgsa_pkg::status_t    last_status_reg, kind_reg;

    logic [7:0]           q1_reg, q2_reg;
    logic [1:0]           dir_q_reg, path_q_reg;
    logic                 inband_reg;
    logic [LEN_W-1:0]     k_reg, i_reg, ti_reg, tj_reg;
    logic [STEP_W-1:0]    s_reg;
    logic [CNT_W-1:0]     cnt_reg;
    bgsa_pkg::score_t     prev_reg [ROW_W];
    bgsa_pkg::score_t     cur_reg  [ROW_W];
    bgsa_pkg::score_t     left_reg, final_reg;

    logic [LEN_W:0]       diff;
    logic [POS_W-1:0]     j_pos, tb_off;
    logic                 j_valid, j_zero, sym_eq, tb_inband;
    bgsa_pkg::score_t     neg_i, diag_v, left_v, up_v, best_v, cell_v, row_tail;
    bgsa_pkg::dir_t       best_d, tb_d, tb_move;
    logic [DIR_AW-1:0]    dir_waddr, dir_raddr;
    logic [PATH_AW-1:0]   path_raddr;
    logic [CNT_W-1:0]     align_count;
    bgsa_pkg::score_t     align_score;
    bgsa_pkg::status_t    align_status;

    // Status flags: length checks for the align decision, compare, row, traceback and readout tests.
    always_comb
    begin
        diff = (len1_reg > len2_reg) ? ((LEN_W + 1)'(len1_reg) - (LEN_W + 1)'(len2_reg))
                                     : ((LEN_W + 1)'(len2_reg) - (LEN_W + 1)'(len1_reg));
        sts.same_len      = (len1_reg == len2_reg);
        sts.len_zero      = (len1_reg == '0);
        sts.reject        = (diff > (LEN_W + 1)'(bgsa_pkg::BAND))
                         || ((LEN_W + 1)'(len1_reg) + 1'b1 < (LEN_W + 1)'(bgsa_pkg::BAND))
                         || ((LEN_W + 1)'(len2_reg) + 1'b1 < (LEN_W + 1)'(bgsa_pkg::BAND));
        sts.cmp_equal     = (q1_reg == q2_reg);
        sts.cmp_last      = (k_reg + 1'b1 == len1_reg);
        sts.row_cell_last = (s_reg == STEP_W'(bgsa_pkg::DIR_WIDTH));
        sts.row_last      = (i_reg == len1_reg);
        sts.tb_end        = (ti_reg == '0) && (tj_reg == '0);
        sts.rd_avail      = (ptr_reg < path_len_reg);
    end

    // One band cell: column position, candidate scores and the chosen direction.
    always_comb
    begin
        j_pos   = POS_W'(i_reg) + POS_W'(s_reg) - POS_W'(bgsa_pkg::BAND + 1);
        j_zero  = (j_pos == '0);
        j_valid = !j_pos[POS_W-1] && !j_zero && (j_pos <= POS_W'(len2_reg));
        neg_i   = SCORE_W'(0) - SCORE_W'(i_reg);
        sym_eq  = (q1_reg == q2_reg) || (q1_reg == bgsa_pkg::WILD_SYM)
               || (q2_reg == bgsa_pkg::WILD_SYM);
        diag_v  = sym_eq ? (prev_reg[0] + SCORE_W'(match_reg))
                         : (prev_reg[0] - SCORE_W'(mismatch_reg));
        left_v  = left_reg - SCORE_W'(gap_reg);
        up_v    = prev_reg[1] - SCORE_W'(gap_reg);
        best_v  = diag_v;
        if (left_v > best_v)
        begin
            best_v = left_v;
        end
        if (up_v > best_v)
        begin
            best_v = up_v;
        end
        if (best_v == diag_v)
        begin
            best_d = bgsa_pkg::DIR_DIAG;
        end
        else if (best_v == left_v)
        begin
            best_d = bgsa_pkg::DIR_LEFT;
        end
        else
        begin
            best_d = bgsa_pkg::DIR_UP;
        end
        cell_v    = j_zero ? neg_i : best_v;
        row_tail  = SCORE_W'(0) - SCORE_W'(i_reg) - SCORE_W'(bgsa_pkg::BAND + 1);
        dir_waddr = DIR_AW'(i_reg * bgsa_pkg::DIR_WIDTH) + DIR_AW'(s_reg - 1'b1);
    end

    // Traceback step.
    always_comb
    begin
        tb_off    = POS_W'(tj_reg) - POS_W'(ti_reg) + POS_W'(bgsa_pkg::BAND);
        tb_inband = (ti_reg != '0) && (tj_reg != '0) && !tb_off[POS_W-1]
                 && (tb_off < POS_W'(bgsa_pkg::DIR_WIDTH));
        dir_raddr = DIR_AW'(ti_reg * bgsa_pkg::DIR_WIDTH) + DIR_AW'(tb_off);
        tb_d      = inband_reg ? bgsa_pkg::dir_t'(dir_q_reg) : bgsa_pkg::DIR_NONE;
        if ((ti_reg != '0) && (tj_reg != '0) && (tb_d == bgsa_pkg::DIR_DIAG))
        begin
            tb_move = bgsa_pkg::DIR_DIAG;
        end
        else if ((ti_reg != '0) && (tb_d == bgsa_pkg::DIR_UP))
        begin
            tb_move = bgsa_pkg::DIR_UP;
        end
        else if (tj_reg != '0)
        begin
            tb_move = bgsa_pkg::DIR_LEFT;
        end
        else
        begin
            tb_move = bgsa_pkg::DIR_UP;
        end
        path_raddr = PATH_AW'(path_len_reg - ptr_reg - 1'b1);
    end

    // Align result fields.
    always_comb
    begin
        case (kind_reg)
            bgsa_pkg::ST_IDENTICAL:
            begin
                align_count = CNT_W'(len1_reg);
                align_score = SCORE_W'(len1_reg) * SCORE_W'(match_reg);
            end
            bgsa_pkg::ST_ALIGNED:
            begin
                align_count = cnt_reg;
                align_score = final_reg;
            end
            default:
            begin
                align_count = '0;
                align_score = '0;
            end
        endcase
        align_status = ovf_reg ? bgsa_pkg::ST_OVERFLOW : kind_reg;
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (cmd.load_first && (len1_reg != LEN_W'(bgsa_pkg::MAX_LEN)))
        begin
            seq1_mem[len1_reg[ADDR_W-1:0]] <= symbol;
        end
        if (cmd.cmp_rd)
        begin
            q1_reg <= seq1_mem[k_reg[ADDR_W-1:0]];
        end
        else if (cmd.row_rd)
        begin
            q1_reg <= seq1_mem[ADDR_W'(i_reg - 1'b1)];
        end
        else if (cmd.rd_issue)
        begin
            q1_reg <= seq1_mem[rd_i_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_second && (len2_reg != LEN_W'(bgsa_pkg::MAX_LEN)))
        begin
            seq2_mem[len2_reg[ADDR_W-1:0]] <= symbol;
        end
        if (cmd.cmp_rd)
        begin
            q2_reg <= seq2_mem[k_reg[ADDR_W-1:0]];
        end
        else if (cmd.cell_rd)
        begin
            q2_reg <= seq2_mem[ADDR_W'(j_pos - 1'b1)];
        end
        else if (cmd.rd_issue)
        begin
            q2_reg <= seq2_mem[rd_j_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cell_calc && j_valid)
        begin
            dir_mem[dir_waddr] <= best_d;
        end
        if (cmd.tb_rd)
        begin
            dir_q_reg  <= dir_mem[dir_raddr];
            inband_reg <= tb_inband;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmp_chk)
        begin
            path_mem[PATH_AW'(k_reg)] <= bgsa_pkg::DIR_DIAG;
        end
        else if (cmd.tb_step)
        begin
            path_mem[cnt_reg[PATH_AW-1:0]] <= tb_move;
        end
        if (cmd.rd_issue)
        begin
            path_q_reg <= path_mem[path_raddr];
        end
    end

    // Fill and traceback working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.cmp_start)
        begin
            k_reg <= '0;
        end
        else if (cmd.cmp_chk)
        begin
            k_reg <= k_reg + 1'b1;
        end

        if (cmd.fill_init)
        begin
            i_reg <= LEN_W'(1);
            for (int k = 0; k < ROW_W; k++)
            begin
                prev_reg[k] <= (k >= bgsa_pkg::BAND) ? SCORE_W'(bgsa_pkg::BAND - k) : '0;
            end
        end
        else if (cmd.row_rd)
        begin
            s_reg    <= STEP_W'(1);
            left_reg <= neg_i;
        end
        else if (cmd.cell_calc)
        begin
            s_reg    <= s_reg + 1'b1;
            left_reg <= cell_v;
            for (int k = 0; k < ROW_W - 1; k++)
            begin
                prev_reg[k] <= prev_reg[k+1];
                cur_reg[k]  <= cur_reg[k+1];
            end
            cur_reg[ROW_W-1] <= cell_v;
            if (j_valid && (i_reg == len1_reg) && (j_pos == POS_W'(len2_reg)))
            begin
                final_reg <= best_v;
            end
        end
        else if (cmd.row_end)
        begin
            for (int k = 0; k < ROW_W - 1; k++)
            begin
                prev_reg[k] <= cur_reg[k+1];
            end
            prev_reg[ROW_W-1] <= row_tail;
            i_reg <= i_reg + 1'b1;
        end

        if (cmd.tb_init)
        begin
            ti_reg  <= len1_reg;
            tj_reg  <= len2_reg;
            cnt_reg <= '0;
        end
        else if (cmd.tb_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (tb_move != bgsa_pkg::DIR_LEFT)
            begin
                ti_reg <= ti_reg - 1'b1;
            end
            if (tb_move != bgsa_pkg::DIR_UP)
            begin
                tj_reg <= tj_reg - 1'b1;
            end
        end
    end

    // Control and configuration registers.
    logic [LEN_W-1:0]  len1_next, len2_next, rd_i_next, rd_j_next;
    logic              ovf_next;
    logic [CNT_W-1:0]  path_len_next, ptr_next;
    bgsa_pkg::status_t last_status_next, kind_next;

    always_comb
    begin
        len1_next        = len1_reg;
        len2_next        = len2_reg;
        ovf_next         = ovf_reg;
        path_len_next    = path_len_reg;
        ptr_next         = ptr_reg;
        rd_i_next        = rd_i_reg;
        rd_j_next        = rd_j_reg;
        last_status_next = last_status_reg;
        kind_next        = cmd.set_kind ? cmd.kind : kind_reg;
        if (cmd.load_first)
        begin
            if (len1_reg != LEN_W'(bgsa_pkg::MAX_LEN))
            begin
                len1_next = len1_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.load_second)
        begin
            if (len2_reg != LEN_W'(bgsa_pkg::MAX_LEN))
            begin
                len2_next = len2_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.align_done)
        begin
            last_status_next = align_status;
            path_len_next    = align_count;
            len1_next        = '0;
            len2_next        = '0;
            ovf_next         = 1'b0;
            ptr_next         = '0;
            rd_i_next        = '0;
            rd_j_next        = '0;
        end
        if (cmd.rd_out)
        begin
            ptr_next = ptr_reg + 1'b1;
            if (path_q_reg != bgsa_pkg::DIR_LEFT)
            begin
                rd_i_next = rd_i_reg + 1'b1;
            end
            if (path_q_reg != bgsa_pkg::DIR_UP)
            begin
                rd_j_next = rd_j_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg       <= bgsa_pkg::MATCH_RESET;
            mismatch_reg    <= bgsa_pkg::MISMATCH_RESET;
            gap_reg         <= bgsa_pkg::GAP_RESET;
            len1_reg        <= '0;
            len2_reg        <= '0;
            ovf_reg         <= 1'b0;
            path_len_reg    <= '0;
            ptr_reg         <= '0;
            rd_i_reg        <= '0;
            rd_j_reg        <= '0;
            last_status_reg <= bgsa_pkg::ST_ALIGNED;
            kind_reg        <= bgsa_pkg::ST_ALIGNED;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    bgsa_pkg::REG_MATCH:    match_reg    <= cfg_data[3:0];
                    bgsa_pkg::REG_MISMATCH: mismatch_reg <= cfg_data[3:0];
                    bgsa_pkg::REG_GAP:      gap_reg      <= cfg_data;
                    default:                ;
                endcase
            end
            len1_reg        <= len1_next;
            len2_reg        <= len2_next;
            ovf_reg         <= ovf_next;
            path_len_reg    <= path_len_next;
            ptr_reg         <= ptr_next;
            rd_i_reg        <= rd_i_next;
            rd_j_reg        <= rd_j_next;
            last_status_reg <= last_status_next;
            kind_reg        <= kind_next;
        end
    end

    // Result formatting.
    always_comb
    begin
        status               = cmd.align_done ? align_status : last_status_reg;
        score                = cmd.align_done ? align_score : '0;
        column_count         = cmd.align_done ? align_count : path_len_reg;
        first_column_symbol  = '0;
        second_column_symbol = '0;
        last_column          = 1'b0;
        if (cmd.rd_out)
        begin
            first_column_symbol  = (path_q_reg == bgsa_pkg::DIR_LEFT) ? bgsa_pkg::GAP_SYM
                                 : (rd_i_reg[ADDR_W] ? 8'd0 : q1_reg);
            second_column_symbol = (path_q_reg == bgsa_pkg::DIR_UP) ? bgsa_pkg::GAP_SYM
                                 : (rd_j_reg[ADDR_W] ? 8'd0 : q2_reg);
            last_column          = (ptr_reg + 1'b1 == path_len_reg);
        end
    end

endmodule

[src/banded_global_sequence_aligner_top.sv]
// Top level of the banded global sequence aligner.
// Instantiates bgsa_ctrl and bgsa_dp; uses bgsa_pkg.

// Loads of either sequence never raise busy. A readout makes one registered
// read of the stores and the path memory and ends with one done strobe; a
// readout with no column left gives none. An align request walks every band
// row as a store read, a read and a calculation step for each of the
// 2*BAND+1 cells and a closing step, then traces back through the direction
// memory with a read and a step per column; an identity check comes first
// when the lengths are equal. Each result is shown for one cycle only,
// marked by done, and must be captured then.
module banded_global_sequence_aligner_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          opcode,
    input  logic [7:0]                          symbol,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [bgsa_pkg::SCORE_W-1:0] score,
    output logic [bgsa_pkg::CNT_W-1:0]          column_count,
    output logic [7:0]                          first_column_symbol,
    output logic [7:0]                          second_column_symbol,
    output logic                                last_column,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [5:0]                          cfg_data
);

    bgsa_pkg::cmd_t cmd;
    bgsa_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    bgsa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    bgsa_dp u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .sts                  (sts),
        .symbol               (symbol),
        .cfg_valid            (cfg_valid),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .status               (status),
        .score                (score),
        .column_count         (column_count),
        .first_column_symbol  (first_column_symbol),
        .second_column_symbol (second_column_symbol),
        .last_column          (last_column)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("Result strobe outside a busy period.");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("Block stayed busy after its result.");

    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == bgsa_pkg::OP_LOAD_FIRST
                            || opcode == bgsa_pkg::OP_LOAD_SECOND)) |=> (!busy && !done))
        else $error("Load request did not complete in one cycle.");

    a_column_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last_column) |-> (column_count != '0))
        else $error("Final column flagged with an empty path.");

endmodule

[tb/tb_banded_global_sequence_aligner_top.sv]
// Self-checking testbench for banded_global_sequence_aligner_top.
// Drives load, align and readout requests and checks each result against a
// built-in banded alignment predictor; depends on bgsa_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_banded_global_sequence_aligner_top;
    import bgsa_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 100;

    typedef struct {
        opcode_t    op;
        logic [7:0] sym;
    } request_t;

    typedef struct {
        logic [1:0]       status;
        logic [15:0]      score;
        logic [CNT_W-1:0] count;
        logic [7:0]       col_a;
        logic [7:0]       col_b;
        logic             last;
    } column_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       opcode;
    logic [7:0]       symbol;
    logic             done;
    logic [1:0]       status;
    logic signed [SCORE_W-1:0] score;
    logic [CNT_W-1:0] column_count;
    logic [7:0]       first_column_symbol;
    logic [7:0]       second_column_symbol;
    logic             last_column;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [5:0]       cfg_data;

    banded_global_sequence_aligner_top dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .opcode               (opcode),
        .symbol               (symbol),
        .done                 (done),
        .status               (status),
        .score                (score),
        .column_count         (column_count),
        .first_column_symbol  (first_column_symbol),
        .second_column_symbol (second_column_symbol),
        .last_column          (last_column),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    request_t pending_q[$];
    column_t  expected_q[$];
    int       issued_cnt;
    int       accepted_cnt;
    int       cfg_cnt;
    int       idle_pct;
    int       errors;
    int       cycles;

    // Predictor state.
    logic [3:0]  match_w;
    logic [3:0]  mismatch_w;
    logic [5:0]  gap_w;
    logic [7:0]  seq_a [0:MAX_LEN-1];
    logic [7:0]  seq_b [0:MAX_LEN-1];
    int          len_a;
    int          len_b;
    bit          overflow;
    int          rows [0:1][0:MAX_LEN+1];
    dir_t        dirs [0:DIR_DEPTH-1];
    dir_t        path [0:PATH_DEPTH-1];
    int          path_cnt;
    int          rd_ptr;
    logic [1:0]  last_st;

    function automatic dir_t dir_lookup(int i, int j);
        int off;
        off = j - i + BAND;
        if (i <= 0 || j <= 0 || i > MAX_LEN || off < 0 || off >= DIR_WIDTH)
            return DIR_NONE;
        return dirs[i * DIR_WIDTH + off];
    endfunction

    function automatic int band_score(int n1, int n2);
        int   p;
        int   c;
        int   jmin;
        int   jmax;
        int   dg;
        int   lf;
        int   up;
        int   best;
        logic [7:0] a;
        logic [7:0] b;
        p = 0;
        foreach (dirs[k]) dirs[k] = DIR_NONE;
        for (int j = 0; j <= n2 && j <= BAND + 1; j++) rows[p][j] = -j;
        for (int i = 1; i <= n1; i++)
        begin
            c = 1 - p;
            jmin = (i > BAND) ? i - BAND : 1;
            jmax = (i + BAND < n2) ? i + BAND : n2;
            a = seq_a[i-1];
            rows[c][jmin-1] = -i;
            for (int j = jmin; j <= jmax; j++)
            begin
                b = seq_b[j-1];
                if (a == b || a == WILD_SYM || b == WILD_SYM)
                    dg = rows[p][j-1] + int'(match_w);
                else
                    dg = rows[p][j-1] - int'(mismatch_w);
                lf = rows[c][j-1] - int'(gap_w);
                up = rows[p][j] - int'(gap_w);
                best = dg;
                if (lf > best) best = lf;
                if (up > best) best = up;
                rows[c][j] = best;
                dirs[i * DIR_WIDTH + (j - i + BAND)] =
                    (best == dg) ? DIR_DIAG : (best == lf) ? DIR_LEFT : DIR_UP;
            end
            if (i + BAND + 1 <= n2) rows[c][i+BAND+1] = -(i + BAND + 1);
            p = c;
        end
        return rows[p][n2];
    endfunction

    function automatic void trace_back(int n1, int n2);
        dir_t rev [0:PATH_DEPTH-1];
        int   cnt;
        int   i;
        int   j;
        dir_t d;
        cnt = 0;
        i = n1;
        j = n2;
        while ((i > 0 || j > 0) && cnt < PATH_DEPTH)
        begin
            d = dir_lookup(i, j);
            if (i > 0 && j > 0 && d == DIR_DIAG)
            begin
                rev[cnt] = DIR_DIAG; i--; j--;
            end
            else if (i > 0 && d == DIR_UP)
            begin
                rev[cnt] = DIR_UP; i--;
            end
            else if (j > 0)
            begin
                rev[cnt] = DIR_LEFT; j--;
            end
            else
            begin
                rev[cnt] = DIR_UP; i--;
            end
            cnt++;
        end
        for (int k = 0; k < cnt; k++) path[k] = rev[cnt-1-k];
        path_cnt = cnt;
    endfunction

    function automatic column_t align_result();
        column_t r;
        int      diff;
        int      sc;
        bit      same;
        diff = (len_a > len_b) ? len_a - len_b : len_b - len_a;
        sc = 0;
        path_cnt = 0;
        same = (len_a == len_b);
        for (int k = 0; k < len_a && same; k++)
            if (seq_a[k] != seq_b[k]) same = 0;
        if (same)
        begin
            sc = len_a * int'(match_w);
            for (int k = 0; k < len_a; k++) path[k] = DIR_DIAG;
            path_cnt = len_a;
            r.status = ST_IDENTICAL;
        end
        else if (diff > BAND || len_a + 1 < BAND || len_b + 1 < BAND)
        begin
            r.status = ST_REJECTED;
        end
        else
        begin
            sc = band_score(len_a, len_b);
            trace_back(len_a, len_b);
            r.status = ST_ALIGNED;
        end
        if (overflow) r.status = ST_OVERFLOW;
        last_st = r.status;
        len_a = 0;
        len_b = 0;
        overflow = 0;
        rd_ptr = 0;
        r.score = sc[15:0];
        r.count = path_cnt[CNT_W-1:0];
        r.col_a = '0;
        r.col_b = '0;
        r.last = 0;
        return r;
    endfunction

    function automatic void apply_request(request_t rq);
        column_t r;
        int      i;
        int      j;
        if (rq.op == OP_LOAD_FIRST || rq.op == OP_LOAD_SECOND)
        begin
            if (rq.op == OP_LOAD_FIRST && len_a < MAX_LEN) seq_a[len_a++] = rq.sym;
            else if (rq.op == OP_LOAD_SECOND && len_b < MAX_LEN) seq_b[len_b++] = rq.sym;
            else overflow = 1;
        end
        else if (rq.op == OP_ALIGN)
        begin
            expected_q.push_back(align_result());
        end
        else if (rd_ptr < path_cnt)
        begin
            i = 0;
            j = 0;
            for (int k = 0; k < rd_ptr; k++)
            begin
                if (path[k] != DIR_LEFT) i++;
                if (path[k] != DIR_UP) j++;
            end
            r.col_a = (i < MAX_LEN) ? seq_a[i] : 8'd0;
            r.col_b = (j < MAX_LEN) ? seq_b[j] : 8'd0;
            if (path[rd_ptr] == DIR_LEFT) r.col_a = GAP_SYM;
            if (path[rd_ptr] == DIR_UP) r.col_b = GAP_SYM;
            r.status = last_st;
            r.score = '0;
            r.count = path_cnt[CNT_W-1:0];
            r.last = (rd_ptr + 1 == path_cnt);
            rd_ptr++;
            expected_q.push_back(r);
        end
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (!(start && accepted_cnt != issued_cnt))
        begin
            if (rst_n && pending_q.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                start <= 1'b1;
                opcode <= pending_q[0].op;
                symbol <= pending_q[0].sym;
                pending_q.pop_front();
                issued_cnt <= issued_cnt + 1;
            end
            else
            begin
                start <= 1'b0;
                opcode <= 2'($urandom);
                symbol <= 8'($urandom);
            end
        end
    end

    always @(posedge clk)
    begin
        column_t  e;
        request_t rq;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with none expected", $time);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (status !== e.status || score !== e.score || column_count !== e.count
                        || first_column_symbol !== e.col_a
                        || second_column_symbol !== e.col_b || last_column !== e.last)
                    begin
                        $display("%0t: expected st=%0d sc=%0d n=%0d a=%0d b=%0d last=%0d",
                                 $time, e.status, $signed(e.score), e.count, e.col_a,
                                 e.col_b, e.last);
                        $display("%0t: actual   st=%0d sc=%0d n=%0d a=%0d b=%0d last=%0d",
                                 $time, status, score, column_count, first_column_symbol,
                                 second_column_symbol, last_column);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                rq.op = opcode_t'(opcode);
                rq.sym = symbol;
                apply_request(rq);
                accepted_cnt++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MATCH:    match_w = cfg_data[3:0];
                    REG_MISMATCH: mismatch_w = cfg_data[3:0];
                    REG_GAP:      gap_w = cfg_data;
                    default:      ;
                endcase
                cfg_cnt++;
            end
        end
    end

    task automatic wait_quiet();
        while (pending_q.size() != 0 || issued_cnt != accepted_cnt || expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        int seen;
        seen = cfg_cnt;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        while (cfg_cnt == seen) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_weights(int m, int x, int g);
        write_reg(REG_MATCH, 6'(m));
        write_reg(REG_MISMATCH, 6'(x));
        write_reg(REG_GAP, 6'(g));
    endtask

    function automatic logic [7:0] pick_base();
        logic [7:0] bases [0:4];
        bases = '{8'd65, 8'd67, 8'd71, 8'd84, WILD_SYM};
        if ($urandom_range(15) == 0) return 8'($urandom);
        return bases[$urandom_range(4)];
    endfunction

    task automatic push(opcode_t op, logic [7:0] sym);
        request_t rq;
        rq.op = op;
        rq.sym = sym;
        pending_q.push_back(rq);
    endtask

    task automatic push_pair(int n1, int n2, bit copy, bit mutate, int reads);
        logic [7:0] a [0:MAX_LEN-1];
        logic [7:0] b [0:MAX_LEN-1];
        int         ia;
        int         ib;
        for (int k = 0; k < n1; k++) a[k] = pick_base();
        for (int k = 0; k < n2; k++)
        begin
            b[k] = (copy && k < n1) ? a[k] : pick_base();
            if (mutate && $urandom_range(5) == 0) b[k] = pick_base();
        end
        ia = 0;
        ib = 0;
        while (ia < n1 || ib < n2)
        begin
            if (ib >= n2 || (ia < n1 && $urandom_range(1))) push(OP_LOAD_FIRST, a[ia++]);
            else push(OP_LOAD_SECOND, b[ib++]);
        end
        push(OP_ALIGN, 8'($urandom));
        for (int k = 0; k < reads; k++)
        begin
            if ($urandom_range(30) == 0) push(OP_LOAD_FIRST, pick_base());
            push(OP_READ, 8'($urandom));
        end
    endtask

    task automatic random_traffic(int count);
        int n1;
        int n2;
        int kind;
        int added;
        added = 0;
        while (added < count)
        begin
            kind = $urandom_range(9);
            n1 = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            if (kind == 0)
            begin
                n2 = n1;
                push_pair(n1, n2, 1, 0, n1 + $urandom_range(1));
            end
            else if (kind == 1)
            begin
                n2 = n1 + BAND + 1 + $urandom_range(3);
                push_pair(n1, n2, 1, 0, 1);
            end
            else if (kind == 2)
            begin
                n1 = $urandom_range(2);
                n2 = $urandom_range(2);
                push_pair(n1, n2, 0, 0, n1 + n2 + 1);
            end
            else if (kind == 3)
            begin
                repeat (4) push(opcode_t'($urandom_range(3)), 8'($urandom));
                n2 = 0;
            end
            else
            begin
                n2 = n1 + $urandom_range(2 * BAND) - BAND;
                if (n2 < 0) n2 = 0;
                push_pair(n1, n2, 1, 1, n1 + n2 + $urandom_range(1));
            end
            added += n1 + n2 + 2;
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        opcode = '0;
        symbol = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        issued_cnt = 0;
        accepted_cnt = 0;
        cfg_cnt = 0;
        idle_pct = 0;
        errors = 0;
        cycles = 0;
        match_w = MATCH_RESET;
        mismatch_w = MISMATCH_RESET;
        gap_w = GAP_RESET;
        len_a = 0;
        len_b = 0;
        overflow = 0;
        path_cnt = 0;
        rd_ptr = 0;
        last_st = ST_ALIGNED;
        foreach (dirs[k]) dirs[k] = DIR_NONE;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        push(OP_READ, 8'hFF);
        push(OP_ALIGN, 8'h00);
        push(OP_READ, 8'h00);
        push_pair(4, 4, 1, 0, 5);
        push(OP_LOAD_FIRST, 8'd65);
        push(OP_LOAD_SECOND, WILD_SYM);
        push(OP_LOAD_FIRST, 8'hFF);
        push(OP_LOAD_SECOND, 8'h00);
        push(OP_ALIGN, 8'h00);
        push(OP_READ, 8'h00);
        push_pair(1, 1, 0, 0, 1);
        push_pair(2, 6, 1, 0, 1);
        push_pair(5, 3, 1, 1, 9);
        wait_quiet();

        set_weights(0, 0, 0);
        push_pair(6, 5, 0, 0, 12);
        for (int k = 0; k <= MAX_LEN; k++) push(OP_LOAD_FIRST, pick_base());
        for (int k = 0; k < 3; k++) push(OP_LOAD_SECOND, pick_base());
        push(OP_ALIGN, 8'h00);
        repeat (2) push(OP_READ, 8'h00);
        random_traffic(25);
        wait_quiet();

        set_weights(15, 15, 63);
        idle_pct = 85;
        random_traffic(25);
        wait_quiet();

        set_weights($urandom_range(15), $urandom_range(15), $urandom_range(63));
        idle_pct = 7;
        random_traffic(25);
        wait_quiet();

        set_weights(MATCH_RESET, MISMATCH_RESET, GAP_RESET);
        idle_pct = 0;
        random_traffic(25);
        wait_quiet();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[banded_global_sequence_aligner_top.f]
src/bgsa_pkg.sv
src/bgsa_ctrl.sv
src/bgsa_dp.sv
src/banded_global_sequence_aligner_top.sv
tb/tb_banded_global_sequence_aligner_top.sv
